// File: hw/rtl/mbd_pkg.sv
`timescale 1ns / 1ps
// mipmap box downsampler: shared types, sizes, channel tables and lane arithmetic
// used by every module of the block except mbd_ram; depends on nothing

package mbd_pkg;

    // largest source level the line store and position counters are built for
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // line store holds one entry per column pair
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int IDX_W      = COL_W - 1;

    // size registers and the effective size derived from them
    localparam int CFG_W        = 12;
    localparam int MAX_DIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SIZE_W       = $clog2(MAX_DIM) + 1;
    localparam int CMP_W        = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int WIDTH_RESET  = 2048;
    localparam int HEIGHT_RESET = 2048;

    // pixel and lane geometry
    localparam int PIXEL_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int LANE_W    = 9;
    localparam int NUM_CHAN  = 4;
    localparam int NUM_FMT   = 4;
    localparam int LANES_W   = LANE_W * NUM_CHAN;
    localparam int AVG_SHIFT = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_RGBA4444 = 2'd1,
        FMT_RGBA5551 = 2'd2,
        FMT_RGBA8888 = 2'd3
    } pixel_fmt_t;

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_LEVEL_WIDTH  = 2'd1,
        CFG_LEVEL_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_EMIT  = 1'b1
    } line_op_t;

    // format and effective level size as seen by the datapath
    typedef struct packed {
        pixel_fmt_t          fmt;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
    } cfg_t;

    // one line store operation, produced at an odd column
    typedef struct packed {
        line_op_t            op;
        logic [IDX_W-1:0]    idx;
        logic [LANES_W-1:0]  lanes;
        logic                last;
    } line_cmd_t;

    // channel position and mask per format, channels r, g, b, a
    localparam logic [4:0] CHAN_SHIFT [NUM_FMT][NUM_CHAN] = '{
        '{5'd11, 5'd5, 5'd0,  5'd0},
        '{5'd12, 5'd8, 5'd4,  5'd0},
        '{5'd11, 5'd6, 5'd1,  5'd0},
        '{5'd0,  5'd8, 5'd16, 5'd24}
    };

    localparam logic [CHAN_W-1:0] CHAN_MASK [NUM_FMT][NUM_CHAN] = '{
        '{8'h1F, 8'h3F, 8'h1F, 8'h00},
        '{8'h0F, 8'h0F, 8'h0F, 8'h0F},
        '{8'h1F, 8'h1F, 8'h1F, 8'h01},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF}
    };

    // size register clamped to the limit, low bit dropped, zero taken as two
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                   input int limit);
        logic [CMP_W-1:0] v;
        logic [CMP_W-1:0] lim;
        lim = CMP_W'(limit);
        v   = CMP_W'(r);
        if (v > lim)
        begin
            v = lim;
        end
        v[0] = 1'b0;
        if (v == '0)
        begin
            v = CMP_W'(2);
        end
        return SIZE_W'(v);
    endfunction

    function automatic logic [CHAN_W-1:0] get_chan(input logic [PIXEL_W-1:0] px,
                                                   input pixel_fmt_t fmt,
                                                   input int c);
        return CHAN_W'(px >> CHAN_SHIFT[fmt][c]) & CHAN_MASK[fmt][c];
    endfunction

    // horizontal pair sums, one 9-bit lane per channel
    function automatic logic [LANES_W-1:0] pair_lanes(input logic [PIXEL_W-1:0] a,
                                                      input logic [PIXEL_W-1:0] b,
                                                      input pixel_fmt_t fmt);
        logic [LANES_W-1:0] lanes;
        lanes = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            lanes[c*LANE_W +: LANE_W] = LANE_W'(get_chan(a, fmt, c)) +
                                        LANE_W'(get_chan(b, fmt, c));
        end
        return lanes;
    endfunction

    // add both rows, divide by four and repack in the current format
    function automatic logic [PIXEL_W-1:0] pack_average(input logic [LANES_W-1:0] prev,
                                                        input logic [LANES_W-1:0] cur,
                                                        input pixel_fmt_t fmt);
        logic [PIXEL_W-1:0] res;
        logic [LANE_W:0]    s;
        logic [CHAN_W-1:0]  v;
        res = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            s   = (LANE_W+1)'(prev[c*LANE_W +: LANE_W]) +
                  (LANE_W+1)'(cur[c*LANE_W +: LANE_W]);
            v   = CHAN_W'(s >> AVG_SHIFT) & CHAN_MASK[fmt][c];
            res = res | (PIXEL_W'(v) << CHAN_SHIFT[fmt][c]);
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/mbd_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies

module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            storage_reg[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= storage_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mbd_front.sv
`timescale 1ns / 1ps
// front end: accepts source pixels, tracks the raster position, holds even pixels
// and turns each odd column into a line store command; depends on mbd_pkg

module mbd_front import mbd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIXEL_W-1:0] s_axis_tdata,   // pixel_in
    input  logic               queue_full,
    output logic               push,
    output line_cmd_t          cmd
);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PIXEL_W-1:0] held_reg, held_next;

    logic               accept;
    logic [SIZE_W-1:0]  col_inc;
    logic [SIZE_W-1:0]  row_inc;
    logic               wrap_col;
    logic               wrap_row;

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // position arithmetic
    assign col_inc  = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_inc  = SIZE_W'(row_reg) + SIZE_W'(1);
    assign wrap_col = (col_inc >= cfg.width);
    assign wrap_row = (row_inc >= cfg.height);

    // classify: odd column stores on even rows, emits on odd rows
    assign push      = accept && col_reg[0];
    assign cmd.op    = row_reg[0] ? OP_EMIT : OP_STORE;
    assign cmd.idx   = col_reg[COL_W-1:1];
    assign cmd.lanes = pair_lanes(held_reg, s_axis_tdata, cfg.fmt);
    assign cmd.last  = (row_inc == cfg.height) && (col_inc == cfg.width);

    // next position and held pixel
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (!col_reg[0])
            begin
                held_next = s_axis_tdata;
            end
            if (wrap_col)
            begin
                col_next = '0;
                row_next = wrap_row ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

endmodule

// File: hw/rtl/mbd_queue.sv
`timescale 1ns / 1ps
// short command fifo between front and back end
// depends on mbd_pkg

module mbd_queue import mbd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_cmd_t cmd_in,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output line_cmd_t cmd_out
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    line_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: hw/rtl/mbd_back.sv
`timescale 1ns / 1ps
// back end: executes line store commands, reads the stored row pair sums,
// averages and holds the result in the output register; depends on mbd_pkg, mbd_ram

module mbd_back import mbd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  pixel_fmt_t         fmt,
    input  logic               cmd_valid,
    input  line_cmd_t          cmd,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIXEL_W-1:0] m_axis_tdata,   // pixel_out
    output logic               m_axis_tlast    // last_of_level
);

    logic                s1_valid_reg, s1_valid_next;
    logic [LANES_W-1:0]  s1_lanes_reg, s1_lanes_next;
    logic                s1_last_reg, s1_last_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]  out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                s1_move;
    logic                is_emit;
    logic                ram_we;
    logic                ram_re;
    logic [LANES_W-1:0]  ram_rdata;

    // a store never waits, an emit waits for a free read stage
    assign s1_move = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign is_emit = (cmd.op == OP_EMIT);
    assign pop     = cmd_valid && (!is_emit || !s1_valid_reg || s1_move);
    assign ram_we  = pop && !is_emit;
    assign ram_re  = pop && is_emit;

    mbd_ram #(
        .WIDTH (LANES_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.idx),
        .wdata (cmd.lanes),
        .re    (ram_re),
        .raddr (cmd.idx),
        .rdata (ram_rdata)
    );

    // read stage and output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_lanes_next  = s1_lanes_reg;
        s1_last_next   = s1_last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = pack_average(ram_rdata, s1_lanes_reg, fmt);
            out_last_next  = s1_last_reg;
        end
        if (ram_re)
        begin
            s1_valid_next = 1'b1;
            s1_lanes_next = cmd.lanes;
            s1_last_next  = cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lanes_reg <= s1_lanes_next;
        s1_last_reg  <= s1_last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: hw/rtl/mipmap_box_downsampler_core.sv
`timescale 1ns / 1ps
// mipmap 2x2 box downsampler top level: configuration registers, front end,
// command queue and back end; depends on mbd_pkg, mbd_front, mbd_queue, mbd_back
//
//   channel   direction  payload                         transaction
//   s_axis    in         tdata = pixel_in                tvalid && tready
//   m_axis    out        tdata = pixel_out, tlast = last tvalid && tready
//   cfg       in         cfg_index, cfg_data             cfg_we
//
// one source pixel per cycle while the command queue is not full; the result of an
// odd-column pixel passes the command queue, the registered line store read and the output register
// reset clears the config registers, position, queue and valid flags; the line store is not cleared
// s_axis_tready drops only when the four-entry command queue is full, which
// happens only through stalls on m_axis

module mipmap_box_downsampler_core import mbd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIXEL_W-1:0] s_axis_tdata,   // [31:0] pixel_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIXEL_W-1:0] m_axis_tdata,   // [31:0] pixel_out
    output logic               m_axis_tlast    // last_of_level
);

    pixel_fmt_t        pixel_format_reg, pixel_format_next;
    logic [CFG_W-1:0]  level_width_reg, level_width_next;
    logic [CFG_W-1:0]  level_height_reg, level_height_next;

    cfg_t              cfg;
    logic              queue_full;
    logic              push;
    line_cmd_t         push_cmd;
    logic              pop;
    logic              cmd_valid;
    line_cmd_t         cmd;

    // register write decode
    always_comb
    begin
        pixel_format_next = pixel_format_reg;
        level_width_next  = level_width_reg;
        level_height_next = level_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PIXEL_FORMAT: pixel_format_next = pixel_fmt_t'(cfg_data[1:0]);
                CFG_LEVEL_WIDTH:  level_width_next  = cfg_data;
                CFG_LEVEL_HEIGHT: level_height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_RGB565;
            level_width_reg  <= CFG_W'(WIDTH_RESET);
            level_height_reg <= CFG_W'(HEIGHT_RESET);
        end
        else
        begin
            pixel_format_reg <= pixel_format_next;
            level_width_reg  <= level_width_next;
            level_height_reg <= level_height_next;
        end
    end

    // effective level size
    assign cfg.fmt    = pixel_format_reg;
    assign cfg.width  = eff_size(level_width_reg, MAX_WIDTH);
    assign cfg.height = eff_size(level_height_reg, MAX_HEIGHT);

    mbd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    mbd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .full    (queue_full),
        .pop     (pop),
        .valid   (cmd_valid),
        .cmd_out (cmd)
    );

    mbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fmt           (pixel_format_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: hw/rtl/mbd_checker.sv
`timescale 1ns / 1ps
// port-level checker for the mipmap box downsampler, bound to the top level
// depends on mbd_pkg and mipmap_box_downsampler_core

module mbd_checker import mbd_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic [1:0]         cfg_index,
    input logic [CFG_W-1:0]   cfg_data,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [PIXEL_W-1:0] s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [PIXEL_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // a result needs at least a full pixel pair
    localparam logic [1:0] PAIR = 2'd2;

    logic [1:0] in_cnt_reg, in_cnt_next;

    // saturating count of accepted source pixels
    always_comb
    begin
        in_cnt_next = in_cnt_reg;
        if (s_axis_tvalid && s_axis_tready && (in_cnt_reg != PAIR))
        begin
            in_cnt_next = in_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg <= '0;
        end
        else
        begin
            in_cnt_reg <= in_cnt_next;
        end
    end

    // the output valid is cleared by the asynchronous reset, so it is low after any edge that sees reset low
    a_reset_no_valid: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid while in reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed or dropped");

    a_result_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (in_cnt_reg == PAIR))
        else $error("result before a full pixel pair was accepted");

    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !$isunknown({cfg_index, cfg_data}))
        else $error("config write with unknown index or data");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tdata))
        else $error("source pixel with unknown data");

endmodule

bind mipmap_box_downsampler_core mbd_checker u_mbd_checker (.*);
